// ===== rtl/ous_pkg.sv =====
// ----------------------------------------------------------------------------
// ous_pkg: shared types and constants for the ordered unique set.
// Defines the set size, the field widths, the action and status codes, and
// the IEEE equality function.
// ----------------------------------------------------------------------------
package ous_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;
  typedef logic [63:0] value_t;

  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_ADD    = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  localparam logic [62:0] ExpAll = 63'h7FF0000000000000;

  // Control that the sequencer sends to every cell.
  typedef struct packed {
    logic              append;
    logic              shift;
    logic [IdxW-1:0]   at;
  } cell_ctl_t;

  function automatic logic is_nan(input value_t v);
    return v[62:0] > ExpAll;
  endfunction

  function automatic logic ieee_eq(input value_t a, input value_t b);
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if (a[62:0] == '0 && b[62:0] == '0) begin
      return 1'b1;
    end
    return a == b;
  endfunction
endpackage

// ===== rtl/ous_if.sv =====
// ----------------------------------------------------------------------------
// ous_if: valid/ready channel.
// Carries one input or result item between a source and a sink.
// ----------------------------------------------------------------------------
interface ous_in_if;
  logic           valid;
  logic           ready;
  logic [1:0]     action;
  logic [63:0]    value;
  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface ous_out_if;
  logic           valid;
  logic           ready;
  logic [4:0]     position;
  logic [1:0]     status;
  logic [4:0]     count;
  modport source (output valid, output position, output status, output count, input ready);
  modport sink (input valid, input position, input status, input count, output ready);
endinterface

// ===== rtl/ous_cell.sv =====
// ----------------------------------------------------------------------------
// ous_cell: one entry of the set.
// Holds a value, compares it with the probe, and takes its upper neighbor's
// value during a compacting shift or the probe on an append.
// ----------------------------------------------------------------------------
module ous_cell (
  input  logic               clk,
  input  logic [ous_pkg::IdxW-1:0] idx,
  input  ous_pkg::cell_ctl_t ctl,
  input  ous_pkg::value_t    probe,
  input  ous_pkg::value_t    upper,
  output ous_pkg::value_t    held,
  output logic               hit
);
  import ous_pkg::*;

  assign hit = ieee_eq(held, probe);

  always_ff @(posedge clk) begin
    if (ctl.append && ctl.at == idx) begin
      held <= probe;
    end else if (ctl.shift && idx >= ctl.at) begin
      held <= upper;
    end
  end
endmodule

// ===== rtl/ordered_unique_set.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_set: insertion-ordered set of distinct doubles.
// Takes an item in S_IDLE, which registers it; S_EVAL then compares it
// against all cells at once, writes the result register and issues the
// append or one-step shift to the chain of cells, holding while the result
// register is full. A new item is taken while a finished result waits to
// be taken, if the result register is free by the time the compare finishes.
// ----------------------------------------------------------------------------
module ordered_unique_set (
  input logic      clk,
  input logic      rst,
  ous_in_if.sink   in_ch,
  ous_out_if.source out_ch
);
  import ous_pkg::*;

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t          state;
  action_t         act;
  value_t          probe;
  logic [CntW-1:0] entry_count;
  cell_ctl_t       ctl;
  value_t          held [Capacity];
  logic [Capacity-1:0] hit;
  logic            found;
  logic [IdxW-1:0] first;
  logic [4:0]      pos_res;
  status_t         st_res;
  logic [CntW-1:0] cnt_res;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    ous_cell u_cell (
      .clk   (clk),
      .idx   (IdxW'(i)),
      .ctl   (ctl),
      .probe (probe),
      .upper ((i == Capacity - 1) ? held[i] : held[(i + 1) % Capacity]),
      .held  (held[i]),
      .hit   (hit[i])
    );
  end

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (hit[i] && CntW'(i) < entry_count) begin
        found = 1'b1;
        first = IdxW'(i);
      end
    end
  end

  always_comb begin
    ctl = '{append: 1'b0, shift: 1'b0, at: first};
    pos_res = found ? 5'(first) : 5'h1F;
    cnt_res = entry_count;
    st_res = found ? ST_DONE : ST_ABSENT;
    if (act == ACT_ADD) begin
      if (found) begin
        st_res = ST_PRESENT;
      end else if (entry_count == CntW'(Capacity)) begin
        st_res = ST_FULL;
      end else begin
        st_res = ST_DONE;
        ctl.append = state == S_EVAL;
        ctl.at = IdxW'(entry_count);
        cnt_res = entry_count + 1'b1;
      end
    end else if (act == ACT_REMOVE && found) begin
      ctl.shift = state == S_EVAL;
      cnt_res = entry_count - 1'b1;
    end
    if (state != S_EVAL || (out_ch.valid && !out_ch.ready)) begin
      ctl.append = 1'b0;
      ctl.shift = 1'b0;
    end
  end

  assign in_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_ch.valid && out_ch.ready) begin
            out_ch.valid <= 1'b0;
          end
          if (in_ch.valid) begin
            act <= in_ch.action;
            probe <= in_ch.value;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.position <= pos_res;
            out_ch.status <= st_res;
            out_ch.count <= 5'(cnt_res);
            entry_count <= cnt_res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/ous_checker.sv =====
// ----------------------------------------------------------------------------
// ous_checker: port-level checks for the ordered unique set.
// Watches results for consistent status, position and count, and checks that inputs are not taken back to back.
// ----------------------------------------------------------------------------
module ous_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] position,
  input logic [1:0] status,
  input logic [4:0] count
);
  import ous_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position))
    else $error("result dropped or changed while stalled");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= 5'(Capacity))
    else $error("count above capacity");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ABSENT || status == ST_FULL) |-> position == 5'h1F)
    else $error("miss with a position");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_PRESENT |-> position != 5'h1F)
    else $error("present without a position");

  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");
endmodule

bind ordered_unique_set ous_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .position(out_ch.position), .status(out_ch.status), .count(out_ch.count)
);

// ===== tb/tb_util_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_util_pkg: stimulus helpers for the ordered unique set testbench.
// Holds the pool of interesting double patterns and the random gap length.
// ----------------------------------------------------------------------------
package tb_util_pkg;
  import ous_pkg::*;

  localparam value_t POS_ZERO = 64'h0000_0000_0000_0000;
  localparam value_t NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam value_t POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam value_t NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam value_t QNAN     = 64'h7FF8_0000_0000_0000;
  localparam value_t SNAN_NEG = 64'hFFF0_0000_0000_0001;
  localparam value_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic value_t rand_value(input value_t pool[$]);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && pool.size() > 0) return pool[$urandom_range(0, pool.size() - 1)];
    if (r < 80) begin
      case ($urandom_range(0, 6))
        0: return POS_ZERO;
        1: return NEG_ZERO;
        2: return POS_INF;
        3: return NEG_INF;
        4: return QNAN;
        5: return SNAN_NEG;
        default: return ALL_ONES;
      endcase
    end
    return {$urandom(), $urandom()};
  endfunction
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ordered_unique_set.
// A directed table covers empty/full sets, signed zeros, NaNs, every action
// and compacting removes; random traffic over a small value pool follows.
// Every result is compared against an in-bench model of the set.
// ----------------------------------------------------------------------------
module testbench;
  import ous_pkg::*;
  import tb_util_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 1000;
  localparam logic [4:0] NO_POS = 5'h1F;
  localparam action_t ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [4:0] position;
    status_t    status;
    logic [4:0] count;
  } outcome_t;

  typedef struct {
    action_t act;
    value_t  val;
    logic    typed;
    outcome_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ous_in_if  in_ch();
  ous_out_if out_ch();

  ordered_unique_set u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  value_t   set_vals[$];
  outcome_t outcome_q[$];
  int       n_errors = 0;
  int       n_checked = 0;
  int       idle_cycles = 0;
  logic     send_done = 1'b0;
  int       st_hits[4];

  function automatic logic same_double(input value_t a, input value_t b);
    logic a_nan, b_nan;
    a_nan = a[62:0] > 63'h7FF0_0000_0000_0000;
    b_nan = b[62:0] > 63'h7FF0_0000_0000_0000;
    if (a_nan || b_nan) return 1'b0;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return a == b;
  endfunction

  function automatic outcome_t apply_set_op(input action_t act, input value_t val);
    int idx;
    outcome_t o;
    idx = -1;
    foreach (set_vals[i]) begin
      if (idx < 0 && same_double(val, set_vals[i])) idx = i;
    end
    if (act == ACT_ADD) begin
      if (idx >= 0) o.status = ST_PRESENT;
      else if (set_vals.size() >= Capacity) o.status = ST_FULL;
      else begin
        set_vals.push_back(val);
        o.status = ST_DONE;
      end
    end else if (act == ACT_REMOVE) begin
      if (idx < 0) o.status = ST_ABSENT;
      else begin
        set_vals.delete(idx);
        o.status = ST_DONE;
      end
    end else begin
      o.status = (idx >= 0) ? ST_DONE : ST_ABSENT;
    end
    o.position = (idx < 0) ? NO_POS : 5'(idx);
    o.count = 5'(set_vals.size());
    return o;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOOKUP;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send_item(input action_t act, input value_t val,
                           input logic typed, input outcome_t res);
    outcome_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = apply_set_op(act, val);
    if (typed && pred != res) begin
      $error("table row disagrees with set model for action %0d value %h", act, val);
      n_errors++;
    end
    outcome_q.push_back(pred);
  endtask

  function automatic stim_row_t row(input action_t a, input value_t v, input logic t,
                                    input logic [4:0] p, input status_t s,
                                    input logic [4:0] c);
    stim_row_t r;
    r.act = a; r.val = v; r.typed = t;
    r.res.position = p; r.res.status = s; r.res.count = c;
    return r;
  endfunction

  // Stimulus
  initial begin
    stim_row_t tbl[$];
    value_t pool[$];
    outcome_t none;
    int r;
    action_t act;
    none = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tbl.push_back(row(ACT_LOOKUP, POS_ZERO, 1'b1, NO_POS, ST_ABSENT, 5'd0));
    tbl.push_back(row(ACT_REMOVE, POS_ZERO, 1'b1, NO_POS, ST_ABSENT, 5'd0));
    tbl.push_back(row(ACT_ADD,    POS_ZERO, 1'b1, NO_POS, ST_DONE, 5'd1));
    tbl.push_back(row(ACT_ADD,    NEG_ZERO, 1'b1, 5'd0, ST_PRESENT, 5'd1));
    tbl.push_back(row(ACT_LOOKUP, NEG_ZERO, 1'b1, 5'd0, ST_DONE, 5'd1));
    tbl.push_back(row(ACT_ADD,    QNAN,     1'b1, NO_POS, ST_DONE, 5'd2));
    tbl.push_back(row(ACT_LOOKUP, QNAN,     1'b1, NO_POS, ST_ABSENT, 5'd2));
    tbl.push_back(row(ACT_ADD,    QNAN,     1'b1, NO_POS, ST_DONE, 5'd3));
    tbl.push_back(row(ACT_ADD,    POS_INF,  1'b1, NO_POS, ST_DONE, 5'd4));
    tbl.push_back(row(ACT_ADD,    NEG_INF,  1'b1, NO_POS, ST_DONE, 5'd5));
    tbl.push_back(row(ACT_ADD,    ALL_ONES, 1'b1, NO_POS, ST_DONE, 5'd6));
    tbl.push_back(row(ACT_SPARE,  POS_INF,  1'b1, 5'd3, ST_DONE, 5'd6));
    tbl.push_back(row(ACT_REMOVE, NEG_ZERO, 1'b1, 5'd0, ST_DONE, 5'd5));
    tbl.push_back(row(ACT_LOOKUP, NEG_INF,  1'b1, 5'd3, ST_DONE, 5'd5));
    for (int i = 0; i < 11; i++)
      tbl.push_back(row(ACT_ADD, 64'h3FF0_0000_0000_0000 + i, 1'b0, 5'd0, ST_DONE, 5'd0));
    tbl.push_back(row(ACT_ADD,    64'h1234, 1'b1, NO_POS, ST_FULL, 5'd16));
    tbl.push_back(row(ACT_REMOVE, 64'h3FF0_0000_0000_000A, 1'b1, 5'd15, ST_DONE, 5'd15));
    foreach (tbl[i]) send_item(tbl[i].act, tbl[i].val, tbl[i].typed, tbl[i].res);

    for (int i = 0; i < 24; i++) pool.push_back({$urandom(), $urandom()});
    pool.push_back(POS_ZERO);
    pool.push_back(NEG_ZERO);
    pool.push_back(QNAN);
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      // lean toward adds below eight entries; from eight on, adds and removes are equally likely
      if (set_vals.size() < 8) act = (r < 55) ? ACT_ADD : (r < 75) ? ACT_REMOVE
                                   : (r < 95) ? ACT_LOOKUP : ACT_SPARE;
      else act = (r < 35) ? ACT_ADD : (r < 70) ? ACT_REMOVE
               : (r < 95) ? ACT_LOOKUP : ACT_SPARE;
      send_item(act, rand_value(pool), 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Result side
  initial begin
    int g;
    logic long_done;
    long_done = 1'b0;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (!long_done && n_checked >= 300) begin
        long_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        st_hits[out_ch.status]++;
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          e = outcome_q.pop_front();
          if (out_ch.position !== e.position) begin
            $error("position: expected %0d got %0d", e.position, out_ch.position);
            n_errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d got %0d", e.status, out_ch.status);
            n_errors++;
          end
          if (out_ch.count !== e.count) begin
            $error("count: expected %0d got %0d", e.count, out_ch.count);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    fork
      begin
        wait (send_done && outcome_q.size() == 0);
        repeat (20) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG);
        n_errors++;
      end
    join_any
    $display("Checked %0d results: done %0d, present %0d, absent %0d, full %0d",
             n_checked, st_hits[ST_DONE], st_hits[ST_PRESENT], st_hits[ST_ABSENT],
             st_hits[ST_FULL]);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ous_pkg.sv
rtl/ous_if.sv
rtl/ous_cell.sv
rtl/ordered_unique_set.sv
rtl/ous_checker.sv
tb/tb_util_pkg.sv
tb/testbench.sv
